// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SRP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication, disabled during reset
`define SRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

// ===== design/srp_pkg.sv =====
// Package for the servo ramp PWM block: types, codes and constants.
`timescale 1ns / 1ps
package srp_pkg;

    // Default width of the period tick counter
    localparam int SRP_COUNT_WIDTH = 16;

    // Field widths
    localparam int PULSE_W   = 16;
    localparam int STEP_W    = 17;
    localparam int CNT8_W    = 8;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 16;

    // Register reset values
    localparam logic [15:0] PERIOD_TICKS_RST = 16'd20000;
    localparam logic [7:0]  RAMP_STEPS_RST   = 8'd10;
    localparam logic [7:0]  STEP_PERIODS_RST = 8'd3;
    localparam logic [7:0]  HOLD_PERIODS_RST = 8'd50;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TICKS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEPS   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIODS = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_PERIODS = 4'd3;

    // Divider: one quotient bit per cycle
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = 5;

    // Output queue depth
    localparam int OBUF_DEPTH = 2;
    localparam int OBUF_CNT_W = 2;

    // Input word kinds
    typedef enum logic {
        FUNC_TICK  = 1'b0,
        FUNC_START = 1'b1
    } srp_func_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RAMP,
        ST_HOLD,
        ST_DIV
    } srp_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic count_adv;
        logic step_adv;
        logic hold_enter;
        logic clear;
        logic busy;
        logic fin;
        logic show_level;
    } srp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic period_end;
        logic step_end;
        logic ramp_last;
        logic hold_end;
        logic hold_zero;
        logic div_done;
    } srp_stat_t;

    // One result word
    typedef struct packed {
        logic               pwm_level;
        logic               busy_res;
        logic [PULSE_W-1:0] width_now;
        logic               finished;
    } srp_res_t;

endpackage

// ===== design/srp_if.sv =====
// Channel interfaces: input words, result words and register writes.
`timescale 1ns / 1ps
interface srp_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [15:0] from_width;
    logic [15:0] to_width;

    modport source (output valid, input ready, output func, output from_width,
                    output to_width);
    modport sink (input valid, output ready, input func, input from_width,
                  input to_width);
endinterface

interface srp_out_if;
    logic        valid;
    logic        ready;
    logic        pwm_level;
    logic        busy_res;
    logic [15:0] width_now;
    logic        finished;

    modport source (output valid, input ready, output pwm_level, output busy_res,
                    output width_now, output finished);
    modport sink (input valid, output ready, input pwm_level, input busy_res,
                  input width_now, input finished);
endinterface

interface srp_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [15:0] data;

    modport source (output valid, input ready, output index, output data);
    modport sink (input valid, output ready, input index, input data);
endinterface

// ===== design/servo_ramp_pwm.sv =====
// Results: one result word per input word, written into the output queue on acceptance.
// Throughput: a tick word every cycle while the output queue has space; a start word
// taken while idle stalls input while the bit-serial divider forms the step size.
// Output: a two-entry queue keeps input moving while one word waits downstream.
// Reset: asynchronous, active low; registers return to defaults, phase to idle.
`timescale 1ns / 1ps
module servo_ramp_pwm
    import srp_pkg::*;
#(
    parameter int COUNT_WIDTH = SRP_COUNT_WIDTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    srp_in_if.sink    in_ch,
    srp_out_if.source out_ch,
    srp_cfg_if.sink   cfg_ch
);

    srp_cmd_t  cmd;
    srp_stat_t stat;
    srp_res_t  res;
    logic      push;
    logic      space;
    logic      cfg_we;

    // Take register writes at any time
    assign cfg_ch.ready = 1'b1;
    assign cfg_we       = cfg_ch.valid && cfg_ch.ready;

    srp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .func     (in_ch.func),
        .space    (space),
        .stat     (stat),
        .in_ready (in_ch.ready),
        .push     (push),
        .cmd      (cmd)
    );

    srp_dpath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_ch.index),
        .cfg_data   (cfg_ch.data),
        .from_width (in_ch.from_width),
        .to_width   (in_ch.to_width),
        .cmd        (cmd),
        .stat       (stat),
        .res        (res)
    );

    srp_obuf u_obuf (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .din    (res),
        .space  (space),
        .out_ch (out_ch)
    );

endmodule

// ===== design/srp_div.sv =====
// Iterative restoring divider: 16-bit magnitude by 8-bit divisor, one bit per cycle.
`timescale 1ns / 1ps
module srp_div
    import srp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] mag,
    input  logic [7:0]  divisor,
    output logic        done,
    output logic [15:0] quot
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0]          quo_reg, quo_next;
    logic [7:0]           rem_reg, rem_next;
    logic [7:0]           dvs_reg, dvs_next;
    logic [8:0]           shifted;
    logic                 fits;

    // Shift in one dividend bit and try a subtract
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[15]};
        fits      = shifted >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            quo_next  = mag;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[14:0], fits};
            rem_next = fits ? 8'(shifted - {1'b0, dvs_reg}) : shifted[7:0];
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold working values
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

// ===== design/srp_dpath.sv =====
// Datapath: registers, period counter, ramp width arithmetic and result word.
`timescale 1ns / 1ps
module srp_dpath
    import srp_pkg::*;
#(
    parameter int COUNT_WIDTH = SRP_COUNT_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    input  logic [PULSE_W-1:0]   from_width,
    input  logic [PULSE_W-1:0]   to_width,
    input  srp_cmd_t             cmd,
    output srp_stat_t            stat,
    output srp_res_t             res
);

    localparam int EXT_W = ((COUNT_WIDTH > PULSE_W) ? COUNT_WIDTH : PULSE_W) + 1;

    logic [15:0]             period_ticks_reg;
    logic [7:0]              ramp_steps_reg;
    logic [7:0]              step_periods_reg;
    logic [7:0]              hold_periods_reg;

    logic [COUNT_WIDTH-1:0]  period_count_reg, period_count_next;
    logic [PULSE_W-1:0]      pulse_now_reg, pulse_now_next;
    logic [PULSE_W-1:0]      pulse_goal_reg, pulse_goal_next;
    logic signed [STEP_W-1:0] step_size_reg, step_size_next;
    logic [CNT8_W-1:0]       steps_done_reg, steps_done_next;
    logic [CNT8_W-1:0]       periods_in_step_reg, periods_in_step_next;
    logic                    diff_neg_reg, diff_neg_next;

    logic [EXT_W-1:0]        pc_ext, per_ext;
    logic [15:0]             per_eff;
    logic [7:0]              sp_eff, dvs_eff;
    logic [STEP_W-1:0]       diff;
    logic [15:0]             diff_mag;
    logic signed [17:0]      adv_sum, goal_s, adv_clamp;
    logic                    step_pos, step_neg;
    logic                    level;
    logic                    div_done;
    logic [15:0]             div_quot;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_ticks_reg <= PERIOD_TICKS_RST;
            ramp_steps_reg   <= RAMP_STEPS_RST;
            step_periods_reg <= STEP_PERIODS_RST;
            hold_periods_reg <= HOLD_PERIODS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PERIOD_TICKS: period_ticks_reg <= cfg_data;
                REG_RAMP_STEPS:   ramp_steps_reg   <= cfg_data[7:0];
                REG_STEP_PERIODS: step_periods_reg <= cfg_data[7:0];
                REG_HOLD_PERIODS: hold_periods_reg <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    // Treat zero period, step length and divisor as one
    assign per_eff = (period_ticks_reg == '0) ? 16'd1 : period_ticks_reg;
    assign sp_eff  = (step_periods_reg == '0) ? 8'd1 : step_periods_reg;
    assign dvs_eff = (ramp_steps_reg == '0) ? 8'd1 : ramp_steps_reg;

    // Take the magnitude of the width difference for the divider
    assign diff     = {1'b0, to_width} - {1'b0, from_width};
    assign diff_mag = diff[STEP_W-1] ? 16'(-diff) : diff[15:0];

    srp_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.load),
        .mag     (diff_mag),
        .divisor (dvs_eff),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Decode period, step and hold boundaries
    assign pc_ext  = EXT_W'(period_count_reg);
    assign per_ext = EXT_W'(per_eff);
    assign level   = pc_ext < EXT_W'(pulse_now_reg);

    always_comb
    begin
        stat.period_end = ((pc_ext + EXT_W'(1)) >= per_ext) || (period_count_reg == '1);
        stat.step_end   = ({1'b0, periods_in_step_reg} + 9'd1) >= {1'b0, sp_eff};
        stat.hold_end   = ({1'b0, periods_in_step_reg} + 9'd1) >= {1'b0, hold_periods_reg};
        stat.ramp_last  = steps_done_reg >= ramp_steps_reg;
        stat.hold_zero  = hold_periods_reg == '0;
        stat.div_done   = div_done;
    end

    // Move the width by one step and clamp at the goal and the field range
    always_comb
    begin
        step_pos  = !step_size_reg[STEP_W-1] && (step_size_reg != '0);
        step_neg  = step_size_reg[STEP_W-1];
        adv_sum   = $signed({2'b00, pulse_now_reg}) + 18'(step_size_reg);
        goal_s    = $signed({2'b00, pulse_goal_reg});
        adv_clamp = adv_sum;
        if (step_pos && (adv_sum > goal_s))
        begin
            adv_clamp = goal_s;
        end
        else if (step_neg && (adv_sum < goal_s))
        begin
            adv_clamp = goal_s;
        end
        if (adv_clamp < 18'sd0)
        begin
            adv_clamp = 18'sd0;
        end
        else if (adv_clamp > 18'sd65535)
        begin
            adv_clamp = 18'sd65535;
        end
    end

    // Update ramp state on commands
    always_comb
    begin
        period_count_next    = period_count_reg;
        pulse_now_next       = pulse_now_reg;
        pulse_goal_next      = pulse_goal_reg;
        step_size_next       = step_size_reg;
        steps_done_next      = steps_done_reg;
        periods_in_step_next = periods_in_step_reg;
        diff_neg_next        = diff_neg_reg;

        if (cmd.load)
        begin
            pulse_now_next  = from_width;
            pulse_goal_next = to_width;
            diff_neg_next   = diff[STEP_W-1];
        end
        else if (cmd.hold_enter)
        begin
            pulse_now_next = pulse_goal_reg;
        end
        else if (cmd.step_adv)
        begin
            pulse_now_next = adv_clamp[15:0];
        end

        if (div_done)
        begin
            step_size_next = diff_neg_reg ? -$signed({1'b0, div_quot})
                                          : $signed({1'b0, div_quot});
        end

        if (cmd.load || cmd.clear)
        begin
            period_count_next    = '0;
            steps_done_next      = '0;
            periods_in_step_next = '0;
        end
        else if (cmd.count_adv)
        begin
            if (stat.period_end)
            begin
                period_count_next = '0;
                if (cmd.step_adv)
                begin
                    periods_in_step_next = '0;
                    steps_done_next      = cmd.hold_enter ? '0
                                                          : steps_done_reg + CNT8_W'(1);
                end
                else
                begin
                    periods_in_step_next = periods_in_step_reg + CNT8_W'(1);
                end
            end
            else
            begin
                period_count_next = period_count_reg + COUNT_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_count_reg    <= '0;
            pulse_now_reg       <= '0;
            pulse_goal_reg      <= '0;
            step_size_reg       <= '0;
            steps_done_reg      <= '0;
            periods_in_step_reg <= '0;
            diff_neg_reg        <= 1'b0;
        end
        else
        begin
            period_count_reg    <= period_count_next;
            pulse_now_reg       <= pulse_now_next;
            pulse_goal_reg      <= pulse_goal_next;
            step_size_reg       <= step_size_next;
            steps_done_reg      <= steps_done_next;
            periods_in_step_reg <= periods_in_step_next;
            diff_neg_reg        <= diff_neg_next;
        end
    end

    // Form the result word for the accepted input word
    always_comb
    begin
        res.pwm_level = cmd.show_level & level;
        res.busy_res  = cmd.busy;
        res.finished  = cmd.fin;
        if (!cmd.busy)
        begin
            res.width_now = '0;
        end
        else if (cmd.load)
        begin
            res.width_now = from_width;
        end
        else
        begin
            res.width_now = pulse_now_reg;
        end
    end

endmodule

// ===== design/srp_ctrl.sv =====
// Controller: ramp phase state machine, input handshake and datapath commands.
`timescale 1ns / 1ps
module srp_ctrl
    import srp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      func,
    input  logic      space,
    input  srp_stat_t stat,
    output logic      in_ready,
    output logic      push,
    output srp_cmd_t  cmd
);

    srp_state_t state_reg, state_next;
    logic       accept;
    logic       is_tick;

    assign in_ready = (state_reg != ST_DIV) && space;
    assign accept   = in_valid && in_ready;
    assign push     = accept;
    assign is_tick  = func == FUNC_TICK;

    // Next phase
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !is_tick)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_RAMP;
                end
            end
            ST_RAMP:
            begin
                if (accept && is_tick && stat.period_end && stat.step_end && stat.ramp_last)
                begin
                    state_next = stat.hold_zero ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (accept && is_tick && stat.period_end && stat.hold_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Commands for the accepted word
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !is_tick)
                begin
                    cmd.load = 1'b1;
                    cmd.busy = 1'b1;
                end
            end
            ST_DIV: ;
            ST_RAMP:
            begin
                if (accept)
                begin
                    cmd.busy = 1'b1;
                    if (is_tick)
                    begin
                        cmd.count_adv  = 1'b1;
                        cmd.show_level = 1'b1;
                        if (stat.period_end && stat.step_end)
                        begin
                            cmd.step_adv = 1'b1;
                            if (stat.ramp_last)
                            begin
                                cmd.hold_enter = 1'b1;
                                if (stat.hold_zero)
                                begin
                                    cmd.fin   = 1'b1;
                                    cmd.clear = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            ST_HOLD:
            begin
                if (accept)
                begin
                    cmd.busy = 1'b1;
                    if (is_tick)
                    begin
                        cmd.count_adv  = 1'b1;
                        cmd.show_level = 1'b1;
                        if (stat.period_end && stat.hold_end)
                        begin
                            cmd.fin   = 1'b1;
                            cmd.clear = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/srp_obuf.sv =====
// Two-entry result queue between the block and the output channel.
`timescale 1ns / 1ps
module srp_obuf
    import srp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  srp_res_t din,
    output logic     space,
    srp_out_if.source out_ch
);

    srp_res_t              mem_reg [OBUF_DEPTH];
    logic                  wr_ptr_reg, wr_ptr_next;
    logic                  rd_ptr_reg, rd_ptr_next;
    logic [OBUF_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  pop;
    srp_res_t              head;

    assign pop   = out_ch.valid && out_ch.ready;
    assign space = cnt_reg != OBUF_CNT_W'(OBUF_DEPTH);
    assign head  = mem_reg[rd_ptr_reg];

    assign out_ch.valid     = cnt_reg != '0;
    assign out_ch.pwm_level = head.pwm_level;
    assign out_ch.busy_res  = head.busy_res;
    assign out_ch.width_now = head.width_now;
    assign out_ch.finished  = head.finished;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + OBUF_CNT_W'(push) - OBUF_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== design/srp_checker.sv =====
// Port-level checker for the servo ramp PWM block and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module srp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        pwm_level,
    input logic        busy_res,
    input logic [15:0] width_now,
    input logic        finished
);

    // A waiting result word stays offered
    `SRP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // Idle results carry no width and a low line
    `SRP_ASSERT_IMPLY(a_idle_zero, clk, rst_n, out_valid && !busy_res, (width_now == 16'd0) && !pwm_level)

    // A high line needs an active ramp and a nonzero width
    `SRP_ASSERT_IMPLY(a_level_busy, clk, rst_n, out_valid && pwm_level, busy_res && (width_now != 16'd0))

    // The finishing word is still marked busy
    `SRP_ASSERT_IMPLY(a_fin_busy, clk, rst_n, out_valid && finished, busy_res)

endmodule

bind servo_ramp_pwm srp_checker u_srp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .pwm_level (out_ch.pwm_level),
    .busy_res  (out_ch.busy_res),
    .width_now (out_ch.width_now),
    .finished  (out_ch.finished)
);
